>>> rtl/csvt_pkg.sv
package csvt_pkg;

    // Byte codes the parser reacts to
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result kinds
    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Register indexes (byte address bit 2)
    localparam logic REG_FIELDS  = 1'b0;
    localparam logic REG_RECORDS = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // Result slots of one bundle, in emission order
    localparam int SLOT_C0   = 0;
    localparam int SLOT_C1   = 1;
    localparam int SLOT_E0   = 2;
    localparam int SLOT_E1   = 3;
    localparam int SLOT_SUM  = 4;
    localparam int NUM_SLOTS = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } t_in;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  content_byte;
        logic [15:0] record_number;
        logic [5:0]  field_number;
        logic [15:0] field_length;
        logic        was_quoted;
        logic        is_corrupted;
        logic        ends_record;
        logic        short_record;
        logic [31:0] bytes_consumed;
        logic [15:0] records_out;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [6:0]  fields_per_record;
        logic [15:0] records_per_chunk;
    } t_cfg;

    typedef struct packed {
        logic        vld;
        logic [15:0] rec;
        logic [5:0]  fld;
        logic [15:0] len;
        logic        quoted;
        logic        corrupt;
        logic        ends;
        logic        short_rec;
    } t_end;

    // Everything one byte produces, at most four results
    typedef struct packed {
        logic [1:0]  n_content;
        logic [7:0]  c_byte;
        logic [15:0] c_rec;
        logic [5:0]  c_fld;
        t_end        e0;
        t_end        e1;
        logic        sum_vld;
        logic [31:0] sum_bytes;
        logic [15:0] sum_recs;
    } t_bundle;

endpackage

>>> rtl/csvt_front.sv
module csvt_front import csvt_pkg::*; #(
    parameter int MAX_FIELDS  = 64,
    parameter int LENGTH_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    input  t_in     i_in_data,
    output logic    o_in_stall,
    input  logic    i_q_full,
    output logic    o_push,
    output t_bundle o_bundle
);

    localparam int FC_W = $clog2(MAX_FIELDS + 1);

    typedef enum logic [5:0] {
        PH_SKIP  = 6'b000001,
        PH_UNQ   = 6'b000010,
        PH_QUO   = 6'b000100,
        PH_PEND  = 6'b001000,
        PH_AFTER = 6'b010000,
        PH_DONE  = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase                 ph;
        logic [LENGTH_BITS-1:0] cnt;
        logic                   cr;
        logic [LENGTH_BITS-1:0] lcr;
        logic [15:0]            rec;
        logic [FC_W-1:0]        fld;
        logic                   cor;
        logic [31:0]            cons;
    } t_pstate;

    localparam t_pstate ST_RESET = '{ph: PH_SKIP, cnt: '0, cr: 1'b0, lcr: '0,
                                     rec: '0, fld: '0, cor: 1'b0, cons: '0};

    t_pstate         r_st, n_st;
    t_bundle         bd;
    logic [FC_W-1:0] eff;
    logic [15:0]     lim;
    logic            accept;
    logic            any_res;

    function automatic void put_content(inout t_pstate s, inout t_bundle b,
                                        input logic [7:0] c, input logic [FC_W-1:0] e);
        if (s.fld < e) begin
            if (b.n_content == 2'd0) begin
                b.c_byte = c;
                b.c_rec  = s.rec;
                b.c_fld  = 6'(s.fld);
            end
            b.n_content = b.n_content + 2'd1;
        end
        if (s.cnt != '1) begin
            s.cnt = s.cnt + 1'b1;
        end
    endfunction

    function automatic void end_field(inout t_pstate s, inout t_bundle b,
                                      input logic [LENGTH_BITS-1:0] len, input logic q,
                                      input logic last, input logic [FC_W-1:0] e,
                                      input logic [15:0] lm);
        t_end ev;
        ev.vld       = 1'b1;
        ev.rec       = s.rec;
        ev.fld       = 6'(s.fld);
        ev.len       = 16'(len);
        ev.quoted    = q;
        ev.corrupt   = s.cor;
        ev.ends      = last;
        ev.short_rec = last && (({1'b0, s.fld} + 1'b1) < {1'b0, e});
        if (s.fld < e) begin
            if (!b.e0.vld) begin
                b.e0 = ev;
            end else begin
                b.e1 = ev;
            end
        end
        if (s.fld < FC_W'(MAX_FIELDS)) begin
            s.fld = s.fld + 1'b1;
        end
        s.cnt = '0;
        s.cr  = 1'b0;
        s.lcr = '0;
        s.cor = 1'b0;
        s.ph  = PH_SKIP;
        if (last) begin
            s.fld = '0;
            if (s.rec != 16'hFFFF) begin
                s.rec = s.rec + 16'd1;
            end
            if (s.rec >= lm) begin
                s.ph = PH_DONE;
            end
        end
    endfunction

    // Effective register values: zero acts as one, fields clamp at MAX_FIELDS
    always_comb begin
        priority if (i_cfg.fields_per_record == '0) begin
            eff = FC_W'(1);
        end else if (32'(i_cfg.fields_per_record) > 32'(MAX_FIELDS)) begin
            eff = FC_W'(MAX_FIELDS);
        end else begin
            eff = FC_W'(i_cfg.fields_per_record);
        end
        lim = (i_cfg.records_per_chunk == '0) ? 16'd1 : i_cfg.records_per_chunk;
    end

    always_comb begin
        t_pstate    s;
        logic [7:0] b;
        logic       taken;
        logic       rec_now;
        s       = r_st;
        bd      = '0;
        b       = i_in_data.data_byte;
        taken   = 1'b0;
        rec_now = 1'b0;

        if (s.ph != PH_DONE) begin
            if (s.cons != '1) begin
                s.cons = s.cons + 32'd1;
            end
            priority if (s.ph == PH_SKIP) begin
                if (b == CH_LF) begin
                    end_field(s, bd, '0, 1'b0, 1'b1, eff, lim);
                    rec_now = 1'b1;
                end else if (b >= CH_SPACE) begin
                    s.ph = (b == CH_QUOTE) ? PH_QUO : PH_UNQ;
                end
            end else if (s.ph == PH_PEND) begin
                if (b == CH_QUOTE) begin
                    // doubled quote is kept as two bytes
                    put_content(s, bd, CH_QUOTE, eff);
                    put_content(s, bd, CH_QUOTE, eff);
                    s.ph  = PH_QUO;
                    taken = 1'b1;
                end else begin
                    s.ph = PH_AFTER;
                end
            end else if (s.ph == PH_QUO) begin
                if (b == CH_QUOTE) begin
                    s.ph = PH_PEND;
                end else begin
                    put_content(s, bd, b, eff);
                end
                taken = 1'b1;
            end else begin
            end

            if (s.ph == PH_UNQ && !taken) begin
                priority if (b == CH_LF) begin
                    end_field(s, bd, s.cr ? s.lcr : s.cnt, 1'b0, 1'b1, eff, lim);
                    rec_now = 1'b1;
                end else if (b == CH_COMMA) begin
                    end_field(s, bd, s.cnt, 1'b0, 1'b0, eff, lim);
                end else begin
                    if (b == CH_CR) begin
                        s.cr  = 1'b1;
                        s.lcr = s.cnt;
                    end
                    put_content(s, bd, b, eff);
                end
            end else if (s.ph == PH_AFTER && !taken) begin
                priority if (b == CH_LF) begin
                    end_field(s, bd, s.cnt, 1'b1, 1'b1, eff, lim);
                    rec_now = 1'b1;
                end else if (b == CH_COMMA) begin
                    end_field(s, bd, s.cnt, 1'b1, 1'b0, eff, lim);
                end else if (b >= CH_SPACE) begin
                    s.cor = 1'b1;
                end else begin
                end
            end
        end

        if (i_in_data.chunk_last) begin
            unique case (s.ph)
                PH_UNQ: begin
                    end_field(s, bd, s.cnt, 1'b0, 1'b1, eff, lim);
                end
                PH_QUO: begin
                    s.cor = 1'b1;
                    end_field(s, bd, s.cnt, 1'b1, 1'b1, eff, lim);
                end
                PH_PEND, PH_AFTER: begin
                    end_field(s, bd, s.cnt, 1'b1, 1'b1, eff, lim);
                end
                PH_SKIP: begin
                    if (!rec_now) begin
                        end_field(s, bd, '0, 1'b0, 1'b1, eff, lim);
                    end
                end
                default: begin
                end
            endcase
            bd.sum_vld   = 1'b1;
            bd.sum_bytes = s.cons;
            bd.sum_recs  = s.rec;
            s            = ST_RESET;
        end

        n_st = accept ? s : r_st;
    end

    assign accept     = i_in_valid && !i_q_full;
    assign any_res    = (bd.n_content != 2'd0) || bd.e0.vld || bd.e1.vld || bd.sum_vld;
    assign o_push     = accept && any_res;
    assign o_bundle   = bd;
    assign o_in_stall = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

>>> rtl/csvt_queue.sv
module csvt_queue import csvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_data,
    output logic    o_empty,
    output logic    o_full
);

    t_bundle               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, r_rptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/csvt_back.sv
module csvt_back import csvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  logic    i_head_valid,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out_data
);

    logic [NUM_SLOTS-1:0] r_done;
    logic                 r_valid;
    t_out                 r_data, n_data;
    logic [NUM_SLOTS-1:0] slots, pending, pick, remain;
    logic                 load;

    always_comb begin
        slots[SLOT_C0]  = i_head.n_content != 2'd0;
        slots[SLOT_C1]  = i_head.n_content == 2'd2;
        slots[SLOT_E0]  = i_head.e0.vld;
        slots[SLOT_E1]  = i_head.e1.vld;
        slots[SLOT_SUM] = i_head.sum_vld;
    end

    // lowest pending slot goes out first
    assign pending = slots & ~r_done;
    assign pick    = pending & (~pending + NUM_SLOTS'(1));
    assign remain  = pending & ~pick;
    assign load    = i_head_valid && (!r_valid || !i_out_stall);
    assign o_pop   = load && (remain == '0);

    always_comb begin
        t_end e;
        e      = pick[SLOT_E0] ? i_head.e0 : i_head.e1;
        n_data = '0;
        priority if (pick[SLOT_C0] || pick[SLOT_C1]) begin
            n_data.item_kind     = KIND_CONTENT;
            n_data.content_byte  = i_head.c_byte;
            n_data.record_number = i_head.c_rec;
            n_data.field_number  = i_head.c_fld;
        end else if (pick[SLOT_E0] || pick[SLOT_E1]) begin
            n_data.item_kind     = KIND_END;
            n_data.record_number = e.rec;
            n_data.field_number  = e.fld;
            n_data.field_length  = e.len;
            n_data.was_quoted    = e.quoted;
            n_data.is_corrupted  = e.corrupt;
            n_data.ends_record   = e.ends;
            n_data.short_record  = e.short_rec;
        end else begin
            n_data.item_kind      = KIND_SUMMARY;
            n_data.bytes_consumed = i_head.sum_bytes;
            n_data.records_out    = i_head.sum_recs;
        end
        n_data.last_of_run = (remain == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= (remain == '0) ? '0 : (r_done | pick);
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

>>> rtl/csv_field_tokenizer.sv
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_stall      i_in_data  (t_in: byte, chunk end)
// out       source     o_out_valid / i_out_stall    o_out_data (t_out: one result)
// config    APB slave  psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One byte is taken per cycle while o_in_stall is low; the parser settles each
// byte combinationally. Each byte yields zero to four results, which leave at
// one per cycle while i_out_stall is low, so the output port sets the pace when
// bytes produce more than one result. A two-entry bundle queue lets the parser
// run on while results drain; o_in_stall rises only when that queue is full.
// Reset is synchronous, active low: registers return to their defaults and the
// parser to the start of a chunk. No clearing pass is needed.
module csv_field_tokenizer import csvt_pkg::*; #(
    parameter int MAX_FIELDS  = 64,
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input bytes
    input  logic        i_in_valid,
    input  t_in         i_in_data,
    output logic        o_in_stall,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    q_push, q_pop, q_empty, q_full;
    t_bundle q_in, q_head;

    // Registers: fields_per_record at 0x0, records_per_chunk at 0x4
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fields_per_record <= 7'd1;
            r_cfg.records_per_chunk <= 16'd1024;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FIELDS:  r_cfg.fields_per_record <= pwdata[6:0];
                REG_RECORDS: r_cfg.records_per_chunk <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIELDS:  prdata = {25'd0, r_cfg.fields_per_record};
            REG_RECORDS: prdata = {16'd0, r_cfg.records_per_chunk};
            default:     prdata = '0;
        endcase
    end

    // Front: byte parser, one transfer per cycle unless q_full, builds result bundles
    csvt_front #(
        .MAX_FIELDS  (MAX_FIELDS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (q_in)
    );

    // Bundle queue between parser and serialiser
    csvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: splits a bundle into single results behind an output register
    csvt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_empty),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    // Parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("bundle pushed into full queue");

    // Serialiser only pops a present bundle
    a_pop_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // A chunk-end transfer always leaves a summary waiting
    a_chunk_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.chunk_last) |=> !q_empty)
        else $error("chunk end produced no bundle");

    // The summary closes its run
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.item_kind == KIND_SUMMARY) |-> o_out_data.last_of_run)
        else $error("summary not marked last of run");

endmodule
